// ===== design/normalized_edit_distance_unit_macros.svh =====
// Assertion macros shared by the RTL. Each checks on the rising edge of
// i_clk and is switched off while the synchronous reset is held.
`ifndef NORMALIZED_EDIT_DISTANCE_UNIT_MACROS_SVH
`define NORMALIZED_EDIT_DISTANCE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NED_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define NED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/ned_pkg.sv =====
`default_nettype none

package ned_pkg;

    localparam int unsigned MAX_LEN_DEF = 64;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned CMD_W       = 2;
    localparam int unsigned ED_W        = 7;
    localparam int unsigned FRAC_BITS   = 16;
    localparam int unsigned NORM_W      = FRAC_BITS + 1;

    localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1) << FRAC_BITS;

    localparam logic [CMD_W-1:0] CMD_FIRST   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SECOND  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic setup;
        logic row_start;
        logic cell_calc;
        logic div_init;
        logic div_step;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic trivial;
        logic last_cell;
        logic last_row;
        logic div_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== design/ned_ram.sv =====
`default_nettype none

module ned_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic                                         i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/ned_ctrl.sv =====
`default_nettype none

module ned_ctrl
    import ned_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [CMD_W-1:0] i_command,
    input  wire t_dp_status       i_status,
    output logic                  o_busy,
    output t_dp_cmd               o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ROW  = 6'b000010,
        S_CELL = 6'b000100,
        S_DIVI = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_first  = accept && (i_command == CMD_FIRST);
                o_cmd.load_second = accept && (i_command == CMD_SECOND);
                if (accept && (i_command == CMD_COMPUTE)) begin
                    o_cmd.setup = 1'b1;
                    n_state     = i_status.trivial ? S_DIVI : S_ROW;
                end
            end
            S_ROW: begin
                o_cmd.row_start = 1'b1;
                n_state         = S_CELL;
            end
            S_CELL: begin
                o_cmd.cell_calc = 1'b1;
                if (i_status.last_cell) begin
                    n_state = i_status.last_row ? S_DIVI : S_ROW;
                end
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/ned_dp.sv =====
`default_nettype none

module ned_dp
    import ned_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [CHAR_W-1:0] i_char_code,
    output t_dp_status             o_status,
    output logic                   o_valid,
    output logic [ED_W-1:0]        o_edit_distance,
    output logic [NORM_W-1:0]      o_normalized_distance,
    output logic                   o_overflow
);

    localparam int unsigned LW   = $clog2(MAX_LEN + 1);
    localparam int unsigned LW1  = LW + 1;
    localparam int unsigned AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned DW   = $clog2(3 * MAX_LEN + 1);
    localparam int unsigned NUMW = LW + NORM_W;
    localparam int unsigned CW   = $clog2(NUMW);

    // String stores and lengths.
    logic [LW-1:0] r_len_a;
    logic [LW-1:0] r_len_b;
    logic          r_drop;
    logic          full_a;
    logic          full_b;

    // Dynamic programme registers: row index, column index, left and
    // diagonal neighbours of the cell being worked on.
    logic [LW-1:0] r_i;
    logic [LW-1:0] r_j;
    logic [LW-1:0] r_left;
    logic [LW-1:0] r_diag;

    // Bit-serial divider.
    logic [DW-1:0]     r_den;
    logic [DW-1:0]     r_rem;
    logic [NUMW-1:0]   r_num;
    logic [NORM_W-1:0] r_quo;
    logic [CW-1:0]     r_cnt;

    logic              r_valid;
    logic [ED_W-1:0]   r_ed;
    logic [NORM_W-1:0] r_norm;
    logic              r_ovf;

    logic [CHAR_W-1:0] a_rd;
    logic [CHAR_W-1:0] b_rd;
    logic [LW-1:0]     cost_rd;
    logic [LW-1:0]     i_minus1;
    logic [LW-1:0]     j_minus1;
    logic [AW-1:0]     stream_raddr;
    logic              stream_re;
    logic [LW-1:0]     above;
    logic [LW1-1:0]    sub_cost;
    logic [LW1-1:0]    up_cost;
    logic [LW1-1:0]    left_cost;
    logic [LW1-1:0]    min1;
    logic [LW1-1:0]    min2;
    logic [LW-1:0]     cell_val;
    logic [DW:0]       rem_sh;
    logic              q_bit;

    assign full_a   = (r_len_a == LW'(MAX_LEN));
    assign full_b   = (r_len_b == LW'(MAX_LEN));
    assign i_minus1 = r_i - LW'(1);
    assign j_minus1 = r_j - LW'(1);

    assign stream_re    = i_cmd.row_start || (i_cmd.cell_calc && !o_status.last_cell);
    assign stream_raddr = i_cmd.row_start ? '0 : r_j[AW-1:0];

    ned_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_first && !full_a),
        .i_waddr (r_len_a[AW-1:0]),
        .i_wdata (i_char_code),
        .i_re    (i_cmd.row_start),
        .i_raddr (i_minus1[AW-1:0]),
        .o_rdata (a_rd)
    );

    ned_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_second_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_second && !full_b),
        .i_waddr (r_len_b[AW-1:0]),
        .i_wdata (i_char_code),
        .i_re    (stream_re),
        .i_raddr (stream_raddr),
        .o_rdata (b_rd)
    );

    // Entry k holds column k+1 of the rolling row; column 0 is always the
    // row index and is never stored.
    ned_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cell_calc),
        .i_waddr (j_minus1[AW-1:0]),
        .i_wdata (cell_val),
        .i_re    (stream_re),
        .i_raddr (stream_raddr),
        .o_rdata (cost_rd)
    );

    // On the first row the row above is the initial row 0, 1, 2, ...
    always_comb begin
        above     = (r_i == LW'(1)) ? r_j : cost_rd;
        sub_cost  = {1'b0, r_diag} + LW1'(a_rd != b_rd);
        up_cost   = {1'b0, above} + LW1'(1);
        left_cost = {1'b0, r_left} + LW1'(1);
        min1      = (up_cost < left_cost) ? up_cost : left_cost;
        min2      = (min1 < sub_cost) ? min1 : sub_cost;
        cell_val  = min2[LW-1:0];
    end

    always_comb begin
        rem_sh = {r_rem, r_num[NUMW-1]};
        q_bit  = (rem_sh >= {1'b0, r_den});
    end

    assign o_status.trivial   = (r_len_a == '0) || (r_len_b == '0);
    assign o_status.last_cell = (r_j == r_len_b);
    assign o_status.last_row  = (r_i == r_len_a);
    assign o_status.div_last  = (r_cnt == CW'(NUMW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a <= '0;
            r_len_b <= '0;
            r_drop  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.load_first) begin
                if (full_a) begin
                    r_drop <= 1'b1;
                end else begin
                    r_len_a <= r_len_a + LW'(1);
                end
            end
            if (i_cmd.load_second) begin
                if (full_b) begin
                    r_drop <= 1'b1;
                end else begin
                    r_len_b <= r_len_b + LW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_len_a <= '0;
                r_len_b <= '0;
                r_drop  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_i    <= LW'(1);
            // With an empty string the distance is the other length.
            r_left <= (r_len_a == '0) ? r_len_b : r_len_a;
        end
        if (i_cmd.row_start) begin
            r_j    <= LW'(1);
            r_left <= r_i;
            r_diag <= i_minus1;
        end
        if (i_cmd.cell_calc) begin
            r_left <= cell_val;
            r_diag <= above;
            if (!o_status.last_cell) begin
                r_j <= r_j + LW'(1);
            end else if (!o_status.last_row) begin
                r_i <= r_i + LW'(1);
            end
        end
        if (i_cmd.div_init) begin
            r_den <= DW'(r_len_a) + DW'(r_len_b) + DW'(r_left);
            r_num <= {r_left, NORM_W'(0)};
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_num <= {r_num[NUMW-2:0], 1'b0};
            r_rem <= q_bit ? DW'(rem_sh - {1'b0, r_den}) : rem_sh[DW-1:0];
            r_quo <= {r_quo[NORM_W-2:0], q_bit};
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.emit) begin
            r_ed   <= ED_W'(r_left);
            r_norm <= (r_den == '0) ? '0 : r_quo;
            r_ovf  <= r_drop;
        end
    end

    assign o_valid               = r_valid;
    assign o_edit_distance       = r_ed;
    assign o_normalized_distance = r_norm;
    assign o_overflow            = r_ovf;

endmodule

`default_nettype wire

// ===== design/normalized_edit_distance_unit.sv =====
// Channel   | Handshake        | Word
// ----------+------------------+-------------------------------------------------
// command   | start / busy     | i_command, i_char_code
// result    | o_valid (strobe) | o_edit_distance, o_normalized_distance, o_overflow
//
// An append word leaves busy low, and the next word may follow.
// A compute word holds busy while the cost table is filled in (skipped with an empty
// string) and the division runs. One cost cell is worked out per cycle, with a
// row-start step before each row; then a restoring divider yields one quotient bit
// per cycle. The result strobe is high in the one cycle in which busy falls; the
// receiver cannot stall it. Reset clears the lengths.
`default_nettype none
`include "normalized_edit_distance_unit_macros.svh"

module normalized_edit_distance_unit
    import ned_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [CMD_W-1:0]  i_command,
    input  wire logic [CHAR_W-1:0] i_char_code,
    output logic                   o_valid,
    output logic [ED_W-1:0]        o_edit_distance,
    output logic [NORM_W-1:0]      o_normalized_distance,
    output logic                   o_overflow
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    ned_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_status  (dp_status),
        .o_busy    (busy),
        .o_cmd     (dp_cmd)
    );

    ned_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (dp_cmd),
        .i_char_code           (i_char_code),
        .o_status              (dp_status),
        .o_valid               (o_valid),
        .o_edit_distance       (o_edit_distance),
        .o_normalized_distance (o_normalized_distance),
        .o_overflow            (o_overflow)
    );

    `NED_ASSERT_NOW(a_valid_idle, o_valid, !busy)
    `NED_ASSERT_NEXT(a_compute_busy, start && !busy && (i_command == CMD_COMPUTE), busy)
    `NED_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid)
    `NED_ASSERT_NOW(a_norm_range, o_valid, o_normalized_distance <= NORM_ONE)

endmodule

`default_nettype wire
